/* hdl/rafls_pkg.sv */
package rafls_pkg;

    localparam int SENSOR_COUNT_DEF = 8;

    localparam int SAMPLE_W = 10;
    localparam int VALUE_W  = 11;
    localparam int SNUM_W   = 4;
    localparam int ENTRY_W  = 8;
    localparam int AXIS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [SAMPLE_W-1:0] FAULT_LOW_RST  = 10'd24;
    localparam logic [SAMPLE_W-1:0] FAULT_HIGH_RST = 10'd998;
    localparam logic [SAMPLE_W-1:0] SPAN_MIN_RST   = 10'd230;
    localparam logic [SAMPLE_W-1:0] SPAN_MAX_RST   = 10'd932;
    localparam logic [7:0]          DEADBAND_RST   = 8'd5;
    localparam logic [ENTRY_W-1:0]  LOG_START_RST  = 8'd0;

    localparam logic [VALUE_W-1:0] NEUTRAL_OUT = 11'd992;
    localparam logic [VALUE_W-1:0] LOW_OUT     = 11'd173;
    localparam logic [VALUE_W-1:0] HIGH_OUT    = 11'd1811;
    localparam logic [VALUE_W-1:0] OUT_SPAN    = HIGH_OUT - LOW_OUT;

    // product of a 10 bit offset and the output span
    localparam int PROD_W    = SAMPLE_W + VALUE_W;
    localparam int DIV_STEPS = VALUE_W;
    localparam int CNT_W     = 4;

    localparam logic KIND_LOG     = 1'b0;
    localparam logic KIND_CHANNEL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAULT_LOW  = 3'd0,
        CFG_FAULT_HIGH = 3'd1,
        CFG_SPAN_MIN   = 3'd2,
        CFG_SPAN_MAX   = 3'd3,
        CFG_DEADBAND   = 3'd4,
        CFG_LOG_START  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_A,
        ST_CHK_B,
        ST_SEL,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } rafls_state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic sel_b;
        logic select;
        logic mul;
        logic div_step;
        logic emit;
    } rafls_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_last;
    } rafls_sts_t;

endpackage

/* hdl/rafls_ctrl.sv */
module rafls_ctrl
    import rafls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rafls_sts_t sts,
    output rafls_cmd_t cmd
);

    rafls_state_t state_reg;
    rafls_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHK_A;
                end
            end
            ST_CHK_A:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_CHK_B;
                end
            end
            ST_CHK_B:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHK_A:
            begin
                cmd.check = sts.out_free;
            end
            ST_CHK_B:
            begin
                cmd.check = sts.out_free;
                cmd.sel_b = 1'b1;
            end
            ST_SEL:
            begin
                cmd.select = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/rafls_dp.sv */
module rafls_dp
    import rafls_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [AXIS_W-1:0]     axis,
    input  logic [SAMPLE_W-1:0]   sample_a,
    input  logic [SAMPLE_W-1:0]   sample_b,
    input  rafls_cmd_t            cmd,
    output rafls_sts_t            sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic [VALUE_W-1:0]    value,
    output logic [SNUM_W-1:0]     sensor_number,
    output logic [ENTRY_W-1:0]    entry_number,
    output logic                  last
);

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    // configuration
    logic [SAMPLE_W-1:0] fault_low_reg;
    logic [SAMPLE_W-1:0] fault_high_reg;
    logic [SAMPLE_W-1:0] span_min_reg;
    logic [SAMPLE_W-1:0] span_max_reg;
    logic [7:0]          deadband_reg;
    logic [ENTRY_W-1:0]  log_idx_reg;
    logic                cfg_wr;

    // input transaction
    logic [AXIS_W-1:0]   axis_reg;
    logic [SAMPLE_W-1:0] a_reg;
    logic [SAMPLE_W-1:0] b_reg;

    // span derived values
    logic [SAMPLE_W:0]   span_sum;
    logic [SAMPLE_W-1:0] mid_reg;
    logic [SAMPLE_W-1:0] diff_reg;
    logic                empty_reg;

    // extremes
    logic [VALUE_W-1:0] hi_ext_reg [SENSOR_COUNT];
    logic [VALUE_W-1:0] lo_ext_reg [SENSOR_COUNT];

    // fault check
    logic [2:0]          sidx;
    logic [5:0]          sidx_w;
    logic [IDX_W-1:0]    slot;
    logic                in_range;
    logic [SAMPLE_W-1:0] reading;
    logic                above;
    logic                below;
    logic                hit;

    // selection and clamp
    logic [SAMPLE_W-1:0] da;
    logic [SAMPLE_W-1:0] db;
    logic [SAMPLE_W-1:0] v_sel;
    logic [SAMPLE_W-1:0] v_lo;
    logic [SAMPLE_W-1:0] v_c;
    logic [SAMPLE_W:0]   db_hi;
    logic [SAMPLE_W:0]   v_plus;
    logic                in_db;
    logic [SAMPLE_W-1:0] v_off_reg;
    logic                neutral_reg;

    // multiply and divide
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] rem_next;
    logic [VALUE_W-1:0]  q_reg;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   trial_sub;
    logic                ge;
    logic [CNT_W-1:0]    cnt_reg;

    // result register
    logic                out_valid_reg;
    logic                kind_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [SNUM_W-1:0]   snum_reg;
    logic [ENTRY_W-1:0]  entry_reg;
    logic                last_reg;

    assign cfg_wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_low_reg  <= FAULT_LOW_RST;
            fault_high_reg <= FAULT_HIGH_RST;
            span_min_reg   <= SPAN_MIN_RST;
            span_max_reg   <= SPAN_MAX_RST;
            deadband_reg   <= DEADBAND_RST;
            log_idx_reg    <= LOG_START_RST;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FAULT_LOW:  fault_low_reg  <= cfg_data;
                    CFG_FAULT_HIGH: fault_high_reg <= cfg_data;
                    CFG_SPAN_MIN:   span_min_reg   <= cfg_data;
                    CFG_SPAN_MAX:   span_max_reg   <= cfg_data;
                    CFG_DEADBAND:   deadband_reg   <= cfg_data[7:0];
                    CFG_LOG_START:  log_idx_reg    <= cfg_data[ENTRY_W-1:0];
                    default:        ;
                endcase
            end
            else if (cmd.check && hit)
            begin
                log_idx_reg <= log_idx_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            axis_reg <= axis;
            a_reg    <= sample_a;
            b_reg    <= sample_b;
        end
    end

    // the user keeps config static while an item is in flight; the block does not enforce it
    assign span_sum = {1'b0, span_min_reg} + {1'b0, span_max_reg};

    always_ff @(posedge clk)
    begin
        mid_reg   <= span_sum[SAMPLE_W:1];
        diff_reg  <= span_max_reg - span_min_reg;
        empty_reg <= (span_max_reg <= span_min_reg);
    end

    assign sidx     = {axis_reg, cmd.sel_b};
    assign sidx_w   = {3'b000, sidx};
    assign slot     = sidx_w[IDX_W-1:0];
    assign in_range = (sidx_w < 6'(SENSOR_COUNT));
    assign reading  = cmd.sel_b ? b_reg : a_reg;
    assign above    = in_range && (reading > fault_high_reg)
                      && ({1'b0, reading} > hi_ext_reg[slot]);
    assign below    = in_range && (reading < fault_low_reg)
                      && ({1'b0, reading} < lo_ext_reg[slot]);
    assign hit      = above || below;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                hi_ext_reg[i] <= NEUTRAL_OUT;
                lo_ext_reg[i] <= NEUTRAL_OUT;
            end
        end
        else if (cmd.check)
        begin
            if (above)
            begin
                hi_ext_reg[slot] <= {1'b0, reading};
            end
            if (below)
            begin
                lo_ext_reg[slot] <= {1'b0, reading};
            end
        end
    end

    assign da     = (a_reg >= mid_reg) ? (a_reg - mid_reg) : (mid_reg - a_reg);
    assign db     = (b_reg >= mid_reg) ? (b_reg - mid_reg) : (mid_reg - b_reg);
    assign v_sel  = (da < db) ? a_reg : b_reg;
    assign v_lo   = (v_sel < span_min_reg) ? span_min_reg : v_sel;
    assign v_c    = (v_lo > span_max_reg) ? span_max_reg : v_lo;
    assign db_hi  = {1'b0, mid_reg} + {3'b000, deadband_reg};
    assign v_plus = {1'b0, v_c} + {3'b000, deadband_reg};
    assign in_db  = ({1'b0, v_c} < db_hi) && (v_plus > {1'b0, mid_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            v_off_reg   <= v_c - span_min_reg;
            neutral_reg <= empty_reg || in_db;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign prod      = PROD_W'(v_off_reg) * PROD_W'(OUT_SPAN);
    assign trial     = {rem_reg, q_reg[VALUE_W-1]};
    assign ge        = (trial >= {1'b0, diff_reg});
    assign trial_sub = trial - {1'b0, diff_reg};
    assign rem_next  = ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg <= prod[PROD_W-1:VALUE_W];
            q_reg   <= prod[VALUE_W-1:0];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[VALUE_W-2:0], ge};
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    assign sts.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.check && hit) || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check && hit)
        begin
            kind_reg  <= KIND_LOG;
            value_reg <= {1'b0, reading};
            snum_reg  <= {1'b0, sidx} + 4'd1;
            entry_reg <= log_idx_reg + 8'd1;
            last_reg  <= 1'b0;
        end
        else if (cmd.emit)
        begin
            kind_reg  <= KIND_CHANNEL;
            value_reg <= neutral_reg ? NEUTRAL_OUT : (q_reg + LOW_OUT);
            snum_reg  <= '0;
            entry_reg <= '0;
            last_reg  <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign value         = value_reg;
    assign sensor_number = snum_reg;
    assign entry_number  = entry_reg;
    assign last          = last_reg;

endmodule

/* hdl/redundant_axis_fault_log_and_scale_unit.sv */
// Redundant axis fault logger and channel scaler.
// Input channel (in_valid/in_ready): one transaction per axis with the
// readings of its two redundant sensors. Output channel (out_valid/out_ready):
// zero to two fault log transactions (kind 0) followed by the scaled channel
// transaction (kind 1, last 1). Configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) is always ready; write it only while the block is idle.
// Order: state CHK_A registers any log record for sensor A, CHK_B the one
// for sensor B; SEL, MUL, the DIV steps and EMIT follow, EMIT registering
// the channel result. CHK_A, CHK_B and EMIT wait for a free output register.
// The bit-serial divider of the linear map and the check, select and multiply
// steps set the rate. One transaction is worked on at a time.
// Reset: configuration returns to its defaults, every stored extreme to 992
// and the log index to 0; the block comes out of reset idle and ready.
// Receiver stall: each result is held in the output register; the sequencer
// waits for that register before writing the next result, so nothing is
// lost and the next input transaction is taken only once the channel result
// has been handed to the output register.
module redundant_axis_fault_log_and_scale_unit
    import rafls_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [AXIS_W-1:0]     axis,
    input  logic [SAMPLE_W-1:0]   sample_a,
    input  logic [SAMPLE_W-1:0]   sample_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic [VALUE_W-1:0]    value,
    output logic [SNUM_W-1:0]     sensor_number,
    output logic [ENTRY_W-1:0]    entry_number,
    output logic                  last
);

    rafls_cmd_t cmd;
    rafls_sts_t sts;

    assign cfg_ready = 1'b1;

    rafls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rafls_dp #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .axis          (axis),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .value         (value),
        .sensor_number (sensor_number),
        .entry_number  (entry_number),
        .last          (last)
    );

endmodule

/* hdl/rafls_checker.sv */
module rafls_checker
    import rafls_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               kind,
    input logic [VALUE_W-1:0] value,
    input logic [SNUM_W-1:0]  sensor_number,
    input logic [ENTRY_W-1:0] entry_number,
    input logic               last
);

    // held result must not change under a stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(kind)
            && $stable(sensor_number) && $stable(entry_number) && $stable(last))
        else $error("result changed while stalled");

    // only the channel result closes a transaction
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == kind))
        else $error("last flag disagrees with kind");

    a_log_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_LOG |-> sensor_number != 4'd0
            && sensor_number <= 4'd8 && value[VALUE_W-1] == 1'b0)
        else $error("bad log record");

    a_chan_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CHANNEL |-> sensor_number == 4'd0
            && entry_number == 8'd0
            && (value == NEUTRAL_OUT || (value >= LOW_OUT && value <= HIGH_OUT)))
        else $error("channel value out of range");

    // one input transaction in flight
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

endmodule

bind redundant_axis_fault_log_and_scale_unit rafls_checker u_rafls_checker (.*);

/* tb/sv/tb_redundant_axis_fault_log_and_scale_unit.sv */
`timescale 1ns / 1ps

module tb_redundant_axis_fault_log_and_scale_unit;
    import rafls_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [AXIS_W-1:0]   axis;
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
    } reading_t;

    typedef struct packed {
        logic                kind;
        logic [VALUE_W-1:0]  value;
        logic [SNUM_W-1:0]   snum;
        logic [ENTRY_W-1:0]  entry;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [AXIS_W-1:0]     axis = '0;
    logic [SAMPLE_W-1:0]   sample_a = '0;
    logic [SAMPLE_W-1:0]   sample_b = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  kind;
    logic [VALUE_W-1:0]    value;
    logic [SNUM_W-1:0]     sensor_number;
    logic [ENTRY_W-1:0]    entry_number;
    logic                  last;

    // model state
    logic [SAMPLE_W-1:0] fault_lo_r;
    logic [SAMPLE_W-1:0] fault_hi_r;
    logic [SAMPLE_W-1:0] span_lo_r;
    logic [SAMPLE_W-1:0] span_hi_r;
    logic [7:0]          dead_r;
    logic [ENTRY_W-1:0]  log_start_r;
    logic [VALUE_W-1:0]  peak_hi [SENSOR_COUNT_DEF];
    logic [VALUE_W-1:0]  peak_lo [SENSOR_COUNT_DEF];
    logic [ENTRY_W-1:0]  log_ptr;

    reading_t   pending_readings [$];
    reg_write_t pending_writes [$];
    result_t    expected_results [$];

    int  send_idle_pct = 26;
    int  recv_idle_pct = 74;
    logic hold_off = 1'b0;
    int  err_count = 0;
    int  quiet_cycles = 0;

    redundant_axis_fault_log_and_scale_unit #(
        .SENSOR_COUNT(SENSOR_COUNT_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .axis(axis),
        .sample_a(sample_a),
        .sample_b(sample_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .value(value),
        .sensor_number(sensor_number),
        .entry_number(entry_number),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void reset_model();
        fault_lo_r  = FAULT_LOW_RST;
        fault_hi_r  = FAULT_HIGH_RST;
        span_lo_r   = SPAN_MIN_RST;
        span_hi_r   = SPAN_MAX_RST;
        dead_r      = DEADBAND_RST;
        log_start_r = LOG_START_RST;
        log_ptr     = LOG_START_RST;
        for (int i = 0; i < SENSOR_COUNT_DEF; i++)
        begin
            peak_hi[i] = NEUTRAL_OUT;
            peak_lo[i] = NEUTRAL_OUT;
        end
    endfunction

    function automatic void apply_cfg_write(reg_write_t w);
        case (w.idx)
            CFG_FAULT_LOW:  fault_lo_r = w.data;
            CFG_FAULT_HIGH: fault_hi_r = w.data;
            CFG_SPAN_MIN:   span_lo_r = w.data;
            CFG_SPAN_MAX:   span_hi_r = w.data;
            CFG_DEADBAND:   dead_r = w.data[7:0];
            CFG_LOG_START:
            begin
                log_start_r = w.data[7:0];
                log_ptr = w.data[7:0];
            end
            default: ;
        endcase
    endfunction

    // logs a new per-sensor extreme outside the fault window
    function automatic void log_if_new_extreme(int idx, logic [SAMPLE_W-1:0] reading);
        logic               hit;
        logic [VALUE_W-1:0] r11;
        result_t            rec;
        hit = 1'b0;
        r11 = {1'b0, reading};
        if (idx >= SENSOR_COUNT_DEF)
            return;
        if (reading <= fault_hi_r && reading >= fault_lo_r)
            return;
        if (reading > fault_hi_r && r11 > peak_hi[idx])
        begin
            peak_hi[idx] = r11;
            hit = 1'b1;
        end
        if (reading < fault_lo_r && r11 < peak_lo[idx])
        begin
            peak_lo[idx] = r11;
            hit = 1'b1;
        end
        if (hit)
        begin
            log_ptr = log_ptr + 8'd1;
            rec.kind  = KIND_LOG;
            rec.value = r11;
            rec.snum  = SNUM_W'(idx + 1);
            rec.entry = log_ptr;
            rec.last  = 1'b0;
            expected_results.push_back(rec);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] scaled_channel(logic [SAMPLE_W-1:0] a,
                                                         logic [SAMPLE_W-1:0] b);
        int lo, hi, mid, da, db, v, dz;
        lo  = int'(span_lo_r);
        hi  = int'(span_hi_r);
        dz  = int'(dead_r);
        mid = (lo + hi) / 2;
        da  = int'(a) - mid;
        db  = int'(b) - mid;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        v = (da < db) ? int'(a) : int'(b);
        if (hi <= lo)
            return NEUTRAL_OUT;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        if (v < mid + dz && v > mid - dz)
            return NEUTRAL_OUT;
        return VALUE_W'((v - lo) * int'(OUT_SPAN) / (hi - lo) + int'(LOW_OUT));
    endfunction

    function automatic void predict_transaction(reading_t it);
        result_t ch;
        log_if_new_extreme(2 * int'(it.axis), it.a);
        log_if_new_extreme(2 * int'(it.axis) + 1, it.b);
        ch.kind  = KIND_CHANNEL;
        ch.value = scaled_channel(it.a, it.b);
        ch.snum  = '0;
        ch.entry = '0;
        ch.last  = 1'b1;
        expected_results.push_back(ch);
    endfunction

    task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    // driver: configuration writes and input transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_cfg_write(pending_writes[0]);
                void'(pending_writes.pop_front());
            end
            if (!(cfg_valid && !cfg_ready))
            begin
                if (pending_writes.size() != 0)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending_writes[0].idx;
                    cfg_data  <= pending_writes[0].data;
                end
                else
                    cfg_valid <= 1'b0;
            end

            if (in_valid && in_ready)
            begin
                predict_transaction(pending_readings[0]);
                void'(pending_readings.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_readings.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    axis     <= pending_readings[0].axis;
                    sample_a <= pending_readings[0].a;
                    sample_b <= pending_readings[0].b;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch("unexpected transaction, value", 16'(value), 16'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                        flag_mismatch("kind", 16'(kind), 16'(want.kind));
                    if (value !== want.value)
                        flag_mismatch("value", 16'(value), 16'(want.value));
                    if (sensor_number !== want.snum)
                        flag_mismatch("sensor_number", 16'(sensor_number), 16'(want.snum));
                    if (entry_number !== want.entry)
                        flag_mismatch("entry_number", 16'(entry_number), 16'(want.entry));
                    if (last !== want.last)
                        flag_mismatch("last", 16'(last), 16'(want.last));
                end
            end
            out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_redundant_axis_fault_log_and_scale_unit: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        pending_writes.push_back(w);
    endtask

    task automatic queue_reading(int ax, int a, int b);
        reading_t it;
        it.axis = AXIS_W'(ax);
        it.a    = SAMPLE_W'(a);
        it.b    = SAMPLE_W'(b);
        pending_readings.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_readings.size() != 0 || pending_writes.size() != 0
               || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // skewed towards the fault window edges and the neutral zone
    function automatic int pick_sample();
        int sel, centre, lo_b, hi_b;
        sel    = $urandom_range(0, 99);
        centre = (int'(span_lo_r) + int'(span_hi_r)) / 2;
        lo_b   = centre - int'(dead_r) - 3;
        hi_b   = centre + int'(dead_r) + 3;
        if (lo_b < 0) lo_b = 0;
        if (hi_b > 1023) hi_b = 1023;
        if (sel < 12)
            return $urandom_range(0, 40);
        if (sel < 24)
            return $urandom_range(980, 1023);
        if (sel < 40)
            return $urandom_range(lo_b, hi_b);
        return $urandom_range(0, 1023);
    endfunction

    task automatic queue_random_readings(int n);
        for (int i = 0; i < n; i++)
            queue_reading($urandom_range(0, 3), pick_sample(), pick_sample());
    endtask

    task automatic queue_random_cfg();
        queue_cfg(CFG_FAULT_LOW, CFG_DATA_W'($urandom_range(0, 300)));
        queue_cfg(CFG_FAULT_HIGH, CFG_DATA_W'($urandom_range(700, 1023)));
        queue_cfg(CFG_SPAN_MIN, CFG_DATA_W'($urandom_range(0, 600)));
        queue_cfg(CFG_SPAN_MAX, CFG_DATA_W'($urandom_range(400, 1023)));
        queue_cfg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(0, 1023)));
        queue_cfg(CFG_LOG_START, CFG_DATA_W'($urandom_range(0, 1023)));
    endtask

    initial
    begin
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: fault extremes, repeats, ties and clamping
        queue_reading(0, 0, 1023);
        queue_reading(0, 1023, 0);
        queue_reading(0, 0, 1023);
        queue_reading(0, 1, 1022);
        queue_reading(1, 10, 581);
        queue_reading(1, 5, 581);
        queue_reading(1, 12, 999);
        queue_reading(2, 576, 586);
        queue_reading(2, 577, 585);
        queue_reading(2, 581, 581);
        queue_reading(2, 100, 200);
        queue_reading(3, 990, 960);
        queue_reading(3, 0, 0);
        wait_drained();

        // inverted fault window, inverted span, log index wrap, masked data bits
        queue_cfg(CFG_FAULT_LOW, 10'd1023);
        queue_cfg(CFG_FAULT_HIGH, 10'd0);
        queue_cfg(CFG_SPAN_MIN, 10'd1023);
        queue_cfg(CFG_SPAN_MAX, 10'd0);
        queue_cfg(CFG_DEADBAND, 10'h300);
        queue_cfg(CFG_LOG_START, 10'h3FF);
        wait_drained();
        queue_reading(1, 500, 995);
        queue_reading(3, 1000, 2);
        queue_reading(2, 300, 700);
        queue_reading(1, 499, 996);
        wait_drained();

        // open window, full span, widest deadband, unused register indexes
        queue_cfg(CFG_FAULT_LOW, 10'd0);
        queue_cfg(CFG_FAULT_HIGH, 10'd1023);
        queue_cfg(CFG_SPAN_MIN, 10'd0);
        queue_cfg(CFG_SPAN_MAX, 10'd1023);
        queue_cfg(CFG_DEADBAND, 10'd255);
        queue_cfg(CFG_SPARE_6, 10'h3FF);
        queue_cfg(CFG_SPARE_7, 10'h3FF);
        queue_cfg(CFG_LOG_START, 10'd0);
        wait_drained();
        queue_reading(0, 0, 1023);
        queue_reading(1, 256, 766);
        queue_reading(2, 255, 767);
        queue_reading(3, 1023, 1023);
        wait_drained();

        // equal span ends
        queue_cfg(CFG_SPAN_MIN, 10'd500);
        queue_cfg(CFG_SPAN_MAX, 10'd500);
        queue_cfg(CFG_DEADBAND, 10'd0);
        wait_drained();
        queue_reading(0, 100, 900);
        queue_reading(3, 500, 500);
        wait_drained();

        // random: defaults, sender light idling, receiver heavy
        queue_cfg(CFG_FAULT_LOW, FAULT_LOW_RST);
        queue_cfg(CFG_FAULT_HIGH, FAULT_HIGH_RST);
        queue_cfg(CFG_SPAN_MIN, SPAN_MIN_RST);
        queue_cfg(CFG_SPAN_MAX, SPAN_MAX_RST);
        queue_cfg(CFG_DEADBAND, CFG_DATA_W'(DEADBAND_RST));
        queue_cfg(CFG_LOG_START, CFG_DATA_W'(LOG_START_RST));
        wait_drained();
        queue_random_readings(95);
        wait_drained();

        send_idle_pct <= 74;
        recv_idle_pct <= 26;
        queue_random_cfg();
        wait_drained();
        queue_random_readings(95);
        wait_drained();

        // no idling; receiver held off so the block backs up
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_cfg(CFG_FAULT_LOW, 10'd100);
        queue_cfg(CFG_FAULT_HIGH, 10'd900);
        queue_cfg(CFG_SPAN_MIN, 10'd0);
        queue_cfg(CFG_SPAN_MAX, 10'd1023);
        queue_cfg(CFG_DEADBAND, 10'd0);
        wait_drained();
        queue_random_readings(95);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        wait_drained();

        queue_random_cfg();
        wait_drained();
        queue_random_readings(95);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("tb_redundant_axis_fault_log_and_scale_unit: done, clean");
        else
            $display("tb_redundant_axis_fault_log_and_scale_unit: done, errors");
        $finish;
    end

endmodule
